/* design/odm_pkg.sv */
// ----------------------------------------------------------------------------
// odm_pkg
// shared constants, opcodes and the distance lookup table for the occupancy
// distance map
// ----------------------------------------------------------------------------
package odm_pkg;

  // map geometry
  localparam int MAP_WIDTH  = 256;
  localparam int MAP_HEIGHT = 256;
  localparam int MAX_RADIUS = 15;

  // fixed field widths
  localparam int OP_W     = 2;
  localparam int COORD_W  = 8;
  localparam int CELL_W   = 4;
  localparam int RADIUS_W = 4;

  // window offset 0 .. 2*radius
  localparam int OFF_W  = RADIUS_W + 1;
  // floor(sqrt(2 * 15 * 15)) = 21
  localparam int DIST_W = 5;
  localparam int LUT_DEPTH = 1 << (2 * RADIUS_W);

  localparam int MAP_DEPTH = MAP_WIDTH * MAP_HEIGHT;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);

  // holds the larger map dimension itself
  localparam int DIM_W = $clog2((MAP_WIDTH > MAP_HEIGHT) ? MAP_WIDTH : MAP_HEIGHT) + 1;
  // signed window position: coordinate plus offset, with sign
  localparam int POS_W = ((DIM_W > COORD_W) ? DIM_W : COORD_W) + 2;

  localparam logic [CELL_W-1:0] RESET_FILL =
      CELL_W'((MAX_RADIUS > 15) ? 15 : MAX_RADIUS);
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(15);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_MARK  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef logic [DIST_W-1:0] dist_lut_t [LUT_DEPTH];

  // indexed by {|dx|, |dy|}, floor of the euclidean distance
  function automatic dist_lut_t build_dist_lut();
    dist_lut_t lut;
    int        s;
    int        r;
    for (int a = 0; a < (1 << RADIUS_W); a++) begin
      for (int b = 0; b < (1 << RADIUS_W); b++) begin
        s = a * a + b * b;
        r = 0;
        for (int k = 1; k < (1 << DIST_W); k++) begin
          if (k * k <= s) begin
            r = k;
          end
        end
        lut[(a << RADIUS_W) | b] = DIST_W'(r);
      end
    end
    return lut;
  endfunction

  localparam dist_lut_t DIST_LUT = build_dist_lut();

endpackage

/* design/odm_req_if.sv */
// ----------------------------------------------------------------------------
// odm_req_if
// request channel: operation code and cell coordinates
// ----------------------------------------------------------------------------
interface odm_req_if;
  import odm_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;

  modport source (output valid, output opcode, output x_coord, output y_coord,
                  input ready);
  modport sink   (input valid, input opcode, input x_coord, input y_coord,
                  output ready);
endinterface

/* design/odm_rsp_if.sv */
// ----------------------------------------------------------------------------
// odm_rsp_if
// response channel: read distance and the finished operation code
// ----------------------------------------------------------------------------
interface odm_rsp_if;
  import odm_pkg::*;

  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] read_distance;
  logic [OP_W-1:0]   completed_op;

  modport source (output valid, output read_distance, output completed_op,
                  input ready);
  modport sink   (input valid, input read_distance, input completed_op,
                  output ready);
endinterface

/* design/odm_ram.sv */
// ----------------------------------------------------------------------------
// odm_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module odm_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/occupancy_distance_map_splat.sv */
// ----------------------------------------------------------------------------
// occupancy_distance_map_splat
// grid of 4-bit distances held in one ram; clear, mark and read operations
// ----------------------------------------------------------------------------
// operations: a read or an unused opcode goes straight to the done state, a mark
//   walks the (2*radius+1)^2 window cells, a clear sweeps all MAP_DEPTH cells
//   (65536 for a 256 x 256 map); each result goes to the result register when it is free
// throughput: one transaction at a time, the next request can be taken in the
//   cycle after the result is loaded; a mark does one ram read-modify-write per
//   window cell per cycle
// reset: a sweep over all MAP_DEPTH cells (65536) fills the map with MAX_RADIUS;
//   no request is taken until it ends, configuration writes are taken
// ----------------------------------------------------------------------------
module occupancy_distance_map_splat (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [odm_pkg::RADIUS_W-1:0]    cfg_wr_data,
  odm_req_if.sink                         req,
  odm_rsp_if.source                       rsp
);
  import odm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CLEAR = 4'b0010,
    ST_MARK  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t              state;
  logic [RADIUS_W-1:0] radius;
  logic [CELL_W-1:0]   fill;
  logic [ADDR_W-1:0]   clr_addr;
  logic                clr_from_op;
  op_t                 op_reg;
  logic [COORD_W-1:0]  cx;
  logic [COORD_W-1:0]  cy;
  logic [RADIUS_W-1:0] win_r;
  logic [OFF_W-1:0]    dx_off;
  logic [OFF_W-1:0]    dy_off;
  logic                rd_inb;

  // write-back stage of the mark read-modify-write
  logic                p_valid;
  logic                p_inb;
  logic [ADDR_W-1:0]   p_addr;
  logic [DIST_W-1:0]   p_dist;

  logic                out_valid;
  logic [CELL_W-1:0]   out_dist;
  logic [OP_W-1:0]     out_op;

  logic                    req_fire;
  logic [OFF_W-1:0]        span;
  logic signed [OFF_W:0]   dx_s;
  logic signed [OFF_W:0]   dy_s;
  logic [OFF_W:0]          dx_mag;
  logic [OFF_W:0]          dy_mag;
  logic signed [POS_W-1:0] nx;
  logic signed [POS_W-1:0] ny;
  logic                    win_inb;
  logic [ADDR_W-1:0]       mark_addr;
  logic [DIST_W-1:0]       win_dist;
  logic                    mark_last;
  logic                    req_inb;
  logic [ADDR_W-1:0]       req_addr;
  logic                    out_free;

  logic                ram_wr_en;
  logic [ADDR_W-1:0]   ram_wr_addr;
  logic [CELL_W-1:0]   ram_wr_data;
  logic                ram_rd_en;
  logic [ADDR_W-1:0]   ram_rd_addr;
  logic [CELL_W-1:0]   ram_rd_data;

  odm_ram #(
    .WIDTH (CELL_W),
    .DEPTH (MAP_DEPTH)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign req.ready         = (state == ST_IDLE) && !rst;
  assign req_fire          = req.valid && req.ready;
  assign rsp.valid         = out_valid;
  assign rsp.read_distance = out_dist;
  assign rsp.completed_op  = out_op;
  assign out_free          = !out_valid || rsp.ready;

  // window position of the current offset pair
  assign span   = {win_r, 1'b0};
  assign dx_s   = signed'({1'b0, dx_off}) - signed'({2'b00, win_r});
  assign dy_s   = signed'({1'b0, dy_off}) - signed'({2'b00, win_r});
  assign dx_mag = dx_s[OFF_W] ? (OFF_W+1)'(-dx_s) : (OFF_W+1)'(dx_s);
  assign dy_mag = dy_s[OFF_W] ? (OFF_W+1)'(-dy_s) : (OFF_W+1)'(dy_s);
  assign win_dist = DIST_LUT[{dx_mag[RADIUS_W-1:0], dy_mag[RADIUS_W-1:0]}];

  assign nx = POS_W'(signed'({1'b0, cx})) + POS_W'(dx_s);
  assign ny = POS_W'(signed'({1'b0, cy})) + POS_W'(dy_s);
  assign win_inb = !nx[POS_W-1] && (nx[POS_W-2:0] < (POS_W-1)'(MAP_WIDTH)) &&
                   !ny[POS_W-1] && (ny[POS_W-2:0] < (POS_W-1)'(MAP_HEIGHT));
  assign mark_addr = ADDR_W'(ADDR_W'(ny[POS_W-2:0]) * ADDR_W'(MAP_WIDTH)) +
                     ADDR_W'(nx[POS_W-2:0]);
  assign mark_last = (dx_off == span) && (dy_off == span);

  assign req_inb  = (DIM_W'(req.x_coord) < DIM_W'(MAP_WIDTH)) &&
                    (DIM_W'(req.y_coord) < DIM_W'(MAP_HEIGHT));
  assign req_addr = ADDR_W'(ADDR_W'(req.y_coord) * ADDR_W'(MAP_WIDTH)) +
                    ADDR_W'(req.x_coord);

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = p_addr;
    ram_wr_data = p_dist[CELL_W-1:0];
    ram_rd_en   = 1'b0;
    ram_rd_addr = mark_addr;
    if (state == ST_CLEAR) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_addr;
      ram_wr_data = fill;
    end else if (p_valid && p_inb && (p_dist < DIST_W'(ram_rd_data))) begin
      ram_wr_en = 1'b1;
    end
    if (state == ST_MARK) begin
      ram_rd_en = 1'b1;
    end else if (req_fire && (op_t'(req.opcode) == OP_READ)) begin
      ram_rd_en   = 1'b1;
      ram_rd_addr = req_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    p_addr <= mark_addr;
    p_dist <= win_dist;
    p_inb  <= win_inb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      fill        <= RESET_FILL;
      clr_from_op <= 1'b0;
      p_valid     <= 1'b0;
      out_valid   <= 1'b0;
      op_reg      <= OP_NONE;
      dx_off      <= '0;
      dy_off      <= '0;
    end else begin
      p_valid <= (state == ST_MARK);
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            op_reg <= op_t'(req.opcode);
            cx     <= req.x_coord;
            cy     <= req.y_coord;
            win_r  <= radius;
            dx_off <= '0;
            dy_off <= '0;
            rd_inb <= req_inb;
            unique case (op_t'(req.opcode))
              OP_CLEAR: begin
                fill        <= radius;
                clr_addr    <= '0;
                clr_from_op <= 1'b1;
                state       <= ST_CLEAR;
              end
              OP_MARK: begin
                state <= ST_MARK;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(MAP_DEPTH - 1)) begin
            state <= clr_from_op ? ST_DONE : ST_IDLE;
          end
        end
        ST_MARK: begin
          if (dy_off == span) begin
            dy_off <= '0;
            dx_off <= dx_off + 1'b1;
          end else begin
            dy_off <= dy_off + 1'b1;
          end
          if (mark_last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // read data stays in the ram output register until taken
          if (out_free) begin
            out_op    <= op_reg;
            out_dist  <= ((op_reg == OP_READ) && rd_inb) ? ram_rd_data : '0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_write_source: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> (state == ST_CLEAR) || $past(state == ST_MARK))
    else $error("map write outside clear sweep or mark write-back");

  a_mark_lowers: assert property (@(posedge clk) disable iff (rst)
    (ram_wr_en && (state != ST_CLEAR)) |-> (DIST_W'(ram_wr_data) < DIST_W'(ram_rd_data)))
    else $error("mark write-back does not lower the cell");

  a_rsp_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.completed_op != OP_READ)) |-> (rsp.read_distance == '0))
    else $error("nonzero distance on a non-read response");

endmodule

/* test/tb_occupancy_distance_map_splat.sv */
// ----------------------------------------------------------------------------
// tb_occupancy_distance_map_splat
// self-checking bench for the occupancy distance map: a local copy of the
// grid predicts every response; directed corner cases come first, then random
// phases at several radius settings with random stalls on both channels
// ----------------------------------------------------------------------------
module tb_occupancy_distance_map_splat;
  timeunit 1ns;
  timeprecision 1ps;

  import odm_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [CELL_W-1:0] dist_val;
    op_t               op;
  } result_t;

  logic                clk;
  logic                rst;
  logic                cfg_wr_en;
  logic [RADIUS_W-1:0] cfg_wr_data;

  odm_req_if req_ch ();
  odm_rsp_if rsp_ch ();

  occupancy_distance_map_splat dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  // predicted grid and radius register
  logic [CELL_W-1:0]   cell_model [MAP_DEPTH];
  logic [RADIUS_W-1:0] model_radius;
  result_t             pending_results [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int hold_left      = 0;
  int clears_left    = 2;
  bit gaps_on        = 1'b1;

  // recently marked cells, reads are aimed around them
  logic [COORD_W-1:0] hot_x [$];
  logic [COORD_W-1:0] hot_y [$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[occupancy_distance_map_splat] ERROR");
      $finish;
    end
  end

  function automatic int floor_root(input int v);
    int r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic void flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
  endfunction

  function automatic void predict_op(input op_t op, input logic [COORD_W-1:0] x,
                                     input logic [COORD_W-1:0] y);
    result_t res;
    int      r;
    int      nx;
    int      ny;
    int      d;
    res.dist_val = '0;
    res.op       = op;
    case (op)
      OP_CLEAR: begin
        for (int i = 0; i < MAP_DEPTH; i++) cell_model[i] = model_radius;
      end
      OP_MARK: begin
        r = int'(model_radius);
        for (int dx = -r; dx <= r; dx++) begin
          for (int dy = -r; dy <= r; dy++) begin
            nx = int'(x) + dx;
            ny = int'(y) + dy;
            if (nx >= 0 && nx < MAP_WIDTH && ny >= 0 && ny < MAP_HEIGHT) begin
              d = floor_root(dx * dx + dy * dy);
              if (d < int'(cell_model[ny * MAP_WIDTH + nx])) begin
                cell_model[ny * MAP_WIDTH + nx] = CELL_W'(d);
              end
            end
          end
        end
      end
      OP_READ: begin
        if (int'(x) < MAP_WIDTH && int'(y) < MAP_HEIGHT) begin
          res.dist_val = cell_model[int'(y) * MAP_WIDTH + int'(x)];
        end
      end
      default: ;
    endcase
    pending_results.push_back(res);
  endfunction

  // checks responses first, then predicts the request taken at the same edge
  always @(posedge clk) begin
    result_t want;
    if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected transaction: distance %0d op %0d",
                                rsp_ch.read_distance, rsp_ch.completed_op));
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.read_distance !== want.dist_val) begin
          flag_mismatch($sformatf("read_distance expected %0d got %0d (op %0d)",
                                  want.dist_val, rsp_ch.read_distance, want.op));
        end
        if (rsp_ch.completed_op !== want.op) begin
          flag_mismatch($sformatf("completed_op expected %0d got %0d",
                                  want.op, rsp_ch.completed_op));
        end
      end
    end
    if (cfg_wr_en) model_radius = cfg_wr_data;
    if (!rst && req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
      predict_op(op_t'(req_ch.opcode), req_ch.x_coord, req_ch.y_coord);
    end
  end

  // response side: long hold-off on request, otherwise short random stalls
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // valid stays high after a transaction; the caller either sends again in
  // the same step or calls stop_and_drain
  task automatic send_op(input op_t op, input logic [COORD_W-1:0] x,
                         input logic [COORD_W-1:0] y);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.opcode  <= op;
    req_ch.x_coord <= x;
    req_ch.y_coord <= y;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  task automatic stop_and_drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_radius(input logic [RADIUS_W-1:0] value);
    stop_and_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [COORD_W-1:0] border_coord();
    if ($urandom_range(0, 1) == 0) return COORD_W'($urandom_range(0, 3));
    return COORD_W'($urandom_range(252, 255));
  endfunction

  task automatic check_reset_contents();
    send_op(OP_READ, 8'd0, 8'd0);
    send_op(OP_READ, 8'd255, 8'd255);
    send_op(OP_READ, 8'd128, 8'd77);
  endtask

  // radius zero touches only the marked cell
  task automatic check_zero_radius_mark();
    write_radius(4'd0);
    send_op(OP_MARK, 8'd50, 8'd60);
    send_op(OP_READ, 8'd50, 8'd60);
    send_op(OP_READ, 8'd51, 8'd60);
    send_op(OP_READ, 8'd50, 8'd61);
  endtask

  // full windows hanging off both corners, distances beyond the stored value
  task automatic check_full_radius_marks();
    write_radius(4'd15);
    send_op(OP_MARK, 8'd0, 8'd0);
    send_op(OP_MARK, 8'd255, 8'd255);
    send_op(OP_MARK, 8'd128, 8'd128);
    send_op(OP_READ, 8'd0, 8'd0);
    send_op(OP_READ, 8'd3, 8'd4);
    send_op(OP_READ, 8'd15, 8'd15);
    send_op(OP_READ, 8'd14, 8'd0);
    send_op(OP_READ, 8'd255, 8'd250);
    send_op(OP_READ, 8'd128, 8'd140);
    send_op(OP_NONE, 8'd255, 8'd255);
    send_op(OP_READ, 8'd200, 8'd30);
  endtask

  task automatic check_clear();
    write_radius(4'd0);
    send_op(OP_CLEAR, 8'd0, 8'd0);
    send_op(OP_READ, 8'd77, 8'd99);
    write_radius(4'd12);
    send_op(OP_CLEAR, 8'd255, 8'd255);
    send_op(OP_READ, 8'd0, 8'd0);
    send_op(OP_READ, 8'd255, 8'd255);
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic check_output_backpressure();
    stop_and_drain();
    hold_left = 2000;
    for (int i = 0; i < 12; i++) begin
      send_op((i % 3 == 0) ? OP_MARK : OP_READ, COORD_W'($urandom),
              COORD_W'($urandom));
    end
    stop_and_drain();
  endtask

  task automatic run_random_phase(input int radius_val, input int count);
    int                 roll;
    int                 k;
    int                 span;
    op_t                op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    write_radius(RADIUS_W'(radius_val));
    span = radius_val + 2;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      x    = COORD_W'($urandom);
      y    = COORD_W'($urandom);
      if (roll < 2 && clears_left > 0) begin
        op = OP_CLEAR;
        clears_left--;
      end else if (roll < 45) begin
        op = OP_MARK;
        if ($urandom_range(0, 3) == 0) begin
          x = border_coord();
          y = border_coord();
        end
        hot_x.push_back(x);
        hot_y.push_back(y);
        if (hot_x.size() > 16) begin
          void'(hot_x.pop_front());
          void'(hot_y.pop_front());
        end
      end else if (roll < 90) begin
        op = OP_READ;
        if (hot_x.size() > 0 && $urandom_range(0, 9) < 7) begin
          k = $urandom_range(0, hot_x.size() - 1);
          x = hot_x[k] + COORD_W'($urandom_range(0, 2 * span)) - COORD_W'(span);
          y = hot_y[k] + COORD_W'($urandom_range(0, 2 * span)) - COORD_W'(span);
        end
      end else if (roll < 95) begin
        op = OP_NONE;
      end else begin
        op = OP_READ;
      end
      send_op(op, x, y);
    end
  endtask

  initial begin
    for (int i = 0; i < MAP_DEPTH; i++) cell_model[i] = RESET_FILL;
    model_radius   = RADIUS_RESET;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    req_ch.valid   = 1'b0;
    req_ch.opcode  = OP_NONE;
    req_ch.x_coord = '0;
    req_ch.y_coord = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    check_reset_contents();
    check_zero_radius_mark();
    check_full_radius_marks();
    check_clear();
    run_random_phase(1, 65);
    run_random_phase(2, 65);
    run_random_phase(3, 65);
    check_output_backpressure();
    run_random_phase(0, 65);
    run_random_phase(4, 65);
    run_random_phase(7, 65);
    run_random_phase(15, 60);
    run_random_phase($urandom_range(1, 15), 65);
    // closing stretch without any idling
    gaps_on = 1'b0;
    run_random_phase(2, 65);

    stop_and_drain();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[occupancy_distance_map_splat] OK");
    end else begin
      $display("[occupancy_distance_map_splat] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/odm_pkg.sv
design/odm_req_if.sv
design/odm_rsp_if.sv
design/odm_ram.sv
design/occupancy_distance_map_splat.sv
test/tb_occupancy_distance_map_splat.sv
